// File: hdl/dqfe_pkg.sv
// Shared types and constants for the four-motor DShot frame encoder.
// Has no dependencies. Every other file in hdl/ refers to it by scoped names.
package dqfe_pkg;

    localparam int MOTORS      = 4;
    localparam int FRAME_BITS  = 16;
    localparam int VALUE_W     = 11;
    localparam int DUTY_W      = 16;
    localparam int SLOT_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [DUTY_W-1:0] COMMAND_MAX = 16'd47;

    // Opcodes of a request.
    localparam logic OP_THROTTLE = 1'b0;
    localparam logic OP_COMMAND  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_FLOOR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_CEIL   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [DUTY_W-1:0]  ONE_DUTY_RST   = 16'd15;
    localparam logic [DUTY_W-1:0]  ZERO_DUTY_RST  = 16'd7;
    localparam logic [VALUE_W-1:0] THR_FLOOR_RST  = 11'd48;
    localparam logic [VALUE_W-1:0] THR_CEIL_RST   = 11'd2047;

    typedef struct packed {
        logic [DUTY_W-1:0]  one_duty;
        logic [DUTY_W-1:0]  zero_duty;
        logic [VALUE_W-1:0] thr_floor;
        logic [VALUE_W-1:0] thr_ceil;
    } cfg_t;

    // One frame per motor, motor 0 in the lowest element.
    typedef logic [MOTORS-1:0][FRAME_BITS-1:0] frame_set_t;

endpackage

// File: hdl/dqfe_front.sv
// Front end: builds the four DShot frames of a request combinationally.
// Depends on dqfe_pkg.
module dqfe_front
(
    input  logic                                  push,
    input  logic                                  full,
    input  logic                                  opcode,
    input  logic [dqfe_pkg::DUTY_W-1:0]           motor_value_0,
    input  logic [dqfe_pkg::DUTY_W-1:0]           motor_value_1,
    input  logic [dqfe_pkg::DUTY_W-1:0]           motor_value_2,
    input  logic [dqfe_pkg::DUTY_W-1:0]           motor_value_3,
    input  dqfe_pkg::cfg_t                        cfg,
    output logic                                  wr_en,
    output dqfe_pkg::frame_set_t                  wr_frames
);

    logic [dqfe_pkg::MOTORS-1:0][dqfe_pkg::DUTY_W-1:0] raw;

    // Clamp or validate one value and pack it with telemetry bit and CRC.
    function automatic logic [dqfe_pkg::FRAME_BITS-1:0] build_frame(
        input logic                          is_cmd,
        input logic [dqfe_pkg::DUTY_W-1:0]   value,
        input dqfe_pkg::cfg_t                c
    );
        logic [dqfe_pkg::VALUE_W-1:0] v;
        logic                         tlm;
        logic [11:0]                  packet;
        logic [3:0]                   crc;
        if (is_cmd == dqfe_pkg::OP_COMMAND)
        begin
            v   = (value > dqfe_pkg::COMMAND_MAX) ? '0 : value[dqfe_pkg::VALUE_W-1:0];
            tlm = (v != '0);
        end
        else
        begin
            v = (value > {5'd0, c.thr_ceil}) ? c.thr_ceil : value[dqfe_pkg::VALUE_W-1:0];
            if ((v != '0) && (v < c.thr_floor))
            begin
                v = c.thr_floor;
            end
            tlm = 1'b0;
        end
        packet = {v, tlm};
        crc    = packet[3:0] ^ packet[7:4] ^ packet[11:8];
        return {packet, crc};
    endfunction

    assign raw   = {motor_value_3, motor_value_2, motor_value_1, motor_value_0};
    assign wr_en = push & ~full;

    always_comb
    begin
        for (int m = 0; m < dqfe_pkg::MOTORS; m++)
        begin
            wr_frames[m] = build_frame(opcode, raw[m], cfg);
        end
    end

endmodule

// File: hdl/dqfe_fifo.sv
// Short queue of built frame sets between the front end and the slot sequencer.
// Depends on dqfe_pkg.
module dqfe_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  dqfe_pkg::frame_set_t  wr_frames,
    input  logic                  rd_en,
    output dqfe_pkg::frame_set_t  rd_frames,
    output logic                  full,
    output logic                  not_empty
);

    dqfe_pkg::frame_set_t                 mem_reg [dqfe_pkg::FIFO_DEPTH];
    logic [dqfe_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [dqfe_pkg::FIFO_PTR_W-1:0]      wr_ptr_next;
    logic [dqfe_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [dqfe_pkg::FIFO_PTR_W-1:0]      rd_ptr_next;
    logic [dqfe_pkg::FIFO_CNT_W-1:0]      count_reg;
    logic [dqfe_pkg::FIFO_CNT_W-1:0]      count_next;
    logic                                 do_wr;
    logic                                 do_rd;

    assign full      = (count_reg == dqfe_pkg::FIFO_CNT_W'(dqfe_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en & ~full;
    assign do_rd     = rd_en & not_empty;
    assign rd_frames = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_frames;
        end
    end

endmodule

// File: hdl/dqfe_back.sv
// Back end: walks the bit slots of the frame set at the queue head and
// registers one output word per slot. Depends on dqfe_pkg.
module dqfe_back
#(
    parameter int SLOTS_PER_FRAME = 18
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  dqfe_pkg::frame_set_t                         rd_frames,
    input  logic                                         not_empty,
    output logic                                         rd_en,
    input  dqfe_pkg::cfg_t                               cfg,
    input  logic                                         pop,
    output logic                                         empty,
    output logic [dqfe_pkg::SLOT_W-1:0]                  slot_index,
    output logic [dqfe_pkg::MOTORS-1:0][dqfe_pkg::DUTY_W-1:0] duty,
    output logic                                         last_slot
);

    localparam logic [dqfe_pkg::SLOT_W-1:0] LAST_SLOT = dqfe_pkg::SLOT_W'(SLOTS_PER_FRAME - 1);
    localparam logic [dqfe_pkg::SLOT_W-1:0] TAIL_START = dqfe_pkg::SLOT_W'(dqfe_pkg::FRAME_BITS);
    localparam logic [3:0] MSB_IDX = 4'(dqfe_pkg::FRAME_BITS - 1);

    logic [dqfe_pkg::SLOT_W-1:0]                            cnt_reg;
    logic [dqfe_pkg::SLOT_W-1:0]                            cnt_next;
    logic                                                   valid_reg;
    logic                                                   valid_next;
    logic [dqfe_pkg::SLOT_W-1:0]                            slot_reg;
    logic [dqfe_pkg::MOTORS-1:0][dqfe_pkg::DUTY_W-1:0]      duty_reg;
    logic [dqfe_pkg::MOTORS-1:0][dqfe_pkg::DUTY_W-1:0]      duty_next;
    logic                                                   last_reg;
    logic                                                   advance;
    logic                                                   at_last;
    logic [3:0]                                             bit_idx;

    // A new slot is produced whenever the queue is not empty and the output register is free or being taken.
    assign advance = not_empty & (~valid_reg | pop);
    assign at_last = (cnt_reg == LAST_SLOT);
    assign rd_en   = advance & at_last;
    assign bit_idx = MSB_IDX - cnt_reg[3:0];

    always_comb
    begin
        for (int m = 0; m < dqfe_pkg::MOTORS; m++)
        begin
            if (cnt_reg >= TAIL_START)
            begin
                duty_next[m] = '0;
            end
            else
            begin
                duty_next[m] = rd_frames[m][bit_idx] ? cfg.one_duty : cfg.zero_duty;
            end
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            cnt_next   = at_last ? '0 : cnt_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot_reg <= cnt_reg;
            duty_reg <= duty_next;
            last_reg <= at_last;
        end
    end

    assign empty      = ~valid_reg;
    assign slot_index = slot_reg;
    assign duty       = duty_reg;
    assign last_slot  = last_reg;

endmodule

// File: hdl/dshot_quad_frame_encoder.sv
// Top level of the four-motor DShot frame encoder: configuration registers,
// front end, frame queue and slot sequencer. Depends on dqfe_pkg and hdl/dqfe_*.sv.
//
// Usage: a request word (opcode and four raw motor values) enters through push/full
// and is accepted on a clock edge with push high and full low. The front end clamps
// or validates each value and builds the four 16-bit frames in the same cycle; the
// frame set goes into a two-entry queue. The slot sequencer takes the frame set at
// the queue head and produces SLOTS_PER_FRAME result words, one per cycle while the
// output is not stalled, most significant frame bit first, followed by tail slots
// whose duties are all zero. The final word of a burst carries last_slot. Results
// leave through empty/pop: the oldest word is on the result ports while empty is
// low and is taken on an edge with pop high. The output register refills in the
// same cycle it is popped, so with pop held high and the queue not empty one word
// leaves every cycle. An accepted request is first written into the queue; its first
// word then moves from the queue head into the output register once that register
// is free or being popped and no earlier burst is in progress. The slot sequencer
// finishes a burst before it takes the next. A frame set stays in the queue until
// its final slot is issued, so requests keep being taken until the queue holds the
// burst in progress and one waiting set. When the receiver stalls, the current word
// holds and the sequencer pauses; the queue then fills and full rises. Reset empties
// the queue, marks the output register empty and returns the configuration registers
// to their defaults. The configuration port (wr_en, wr_index, wr_data) writes one
// register per cycle and is meant to be used only while no burst is outstanding.
module dshot_quad_frame_encoder
#(
    parameter int SLOTS_PER_FRAME = 18
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [dqfe_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [dqfe_pkg::DUTY_W-1:0]           wr_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  opcode,
    input  logic [dqfe_pkg::DUTY_W-1:0]           motor_value_0,
    input  logic [dqfe_pkg::DUTY_W-1:0]           motor_value_1,
    input  logic [dqfe_pkg::DUTY_W-1:0]           motor_value_2,
    input  logic [dqfe_pkg::DUTY_W-1:0]           motor_value_3,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [dqfe_pkg::SLOT_W-1:0]           slot_index,
    output logic [dqfe_pkg::DUTY_W-1:0]           duty_0,
    output logic [dqfe_pkg::DUTY_W-1:0]           duty_1,
    output logic [dqfe_pkg::DUTY_W-1:0]           duty_2,
    output logic [dqfe_pkg::DUTY_W-1:0]           duty_3,
    output logic                                  last_slot
);

    dqfe_pkg::cfg_t                                         cfg_reg;
    dqfe_pkg::cfg_t                                         cfg_next;
    logic                                                   q_wr_en;
    dqfe_pkg::frame_set_t                                   q_wr_frames;
    logic                                                   q_rd_en;
    dqfe_pkg::frame_set_t                                   q_rd_frames;
    logic                                                   q_not_empty;
    logic [dqfe_pkg::MOTORS-1:0][dqfe_pkg::DUTY_W-1:0]      duty;

    // Configuration registers. Values are cut to each register's width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                dqfe_pkg::REG_ONE_DUTY:  cfg_next.one_duty  = wr_data;
                dqfe_pkg::REG_ZERO_DUTY: cfg_next.zero_duty = wr_data;
                dqfe_pkg::REG_THR_FLOOR: cfg_next.thr_floor = wr_data[dqfe_pkg::VALUE_W-1:0];
                dqfe_pkg::REG_THR_CEIL:  cfg_next.thr_ceil  = wr_data[dqfe_pkg::VALUE_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_duty  <= dqfe_pkg::ONE_DUTY_RST;
            cfg_reg.zero_duty <= dqfe_pkg::ZERO_DUTY_RST;
            cfg_reg.thr_floor <= dqfe_pkg::THR_FLOOR_RST;
            cfg_reg.thr_ceil  <= dqfe_pkg::THR_CEIL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dqfe_front u_front
    (
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .motor_value_0 (motor_value_0),
        .motor_value_1 (motor_value_1),
        .motor_value_2 (motor_value_2),
        .motor_value_3 (motor_value_3),
        .cfg           (cfg_reg),
        .wr_en         (q_wr_en),
        .wr_frames     (q_wr_frames)
    );

    dqfe_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr_en),
        .wr_frames (q_wr_frames),
        .rd_en     (q_rd_en),
        .rd_frames (q_rd_frames),
        .full      (full),
        .not_empty (q_not_empty)
    );

    dqfe_back #(
        .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_frames  (q_rd_frames),
        .not_empty  (q_not_empty),
        .rd_en      (q_rd_en),
        .cfg        (cfg_reg),
        .pop        (pop),
        .empty      (empty),
        .slot_index (slot_index),
        .duty       (duty),
        .last_slot  (last_slot)
    );

    assign duty_0 = duty[0];
    assign duty_1 = duty[1];
    assign duty_2 = duty[2];
    assign duty_3 = duty[3];

`ifndef ASSERT_OFF
    // The end-of-burst mark sits only on the final slot number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_slot) |-> (slot_index == dqfe_pkg::SLOT_W'(SLOTS_PER_FRAME - 1)))
    else $error("last_slot on a slot other than the final one");

    // Tail slots drive zero duty on every channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && slot_index >= dqfe_pkg::SLOT_W'(dqfe_pkg::FRAME_BITS))
        |-> (duty_0 == '0 && duty_1 == '0 && duty_2 == '0 && duty_3 == '0))
    else $error("nonzero duty in a tail slot");

    // Frame slots carry one of the two configured duty values on channels 0 and 3.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && slot_index < dqfe_pkg::SLOT_W'(dqfe_pkg::FRAME_BITS))
        |-> ((duty_0 == cfg_reg.one_duty || duty_0 == cfg_reg.zero_duty)
          && (duty_3 == cfg_reg.one_duty || duty_3 == cfg_reg.zero_duty)))
    else $error("frame slot duty is neither configured value");
`endif

endmodule
